// ===== sv/asft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asft_pkg
// shared constants, decode codes and helpers for the stack frame tracker
// ----------------------------------------------------------------------------
package asft_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [3:0] COND_ALWAYS = 4'he;
  localparam logic [3:0] REG_SP      = 4'd13;
  localparam logic [3:0] REG_LR      = 4'd14;

  localparam logic [WORD_W-1:0] UNKNOWN_POS = '1;

  // instruction class field [27:25]
  localparam logic [2:0] CLS_DP_REG  = 3'd0;
  localparam logic [2:0] CLS_DP_IMM  = 3'd1;
  localparam logic [2:0] CLS_LS_IMM  = 3'd2;
  localparam logic [2:0] CLS_LS_REG  = 3'd3;
  localparam logic [2:0] CLS_BLOCK   = 3'd4;
  localparam logic [2:0] CLS_BRANCH  = 3'd5;
  localparam logic [2:0] CLS_COPROC  = 3'd6;
  localparam logic [2:0] CLS_OTHER   = 3'd7;

  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd4;

  // block transfer addressing mode, {P, U}
  localparam logic [1:0] MODE_DA = 2'b00;
  localparam logic [1:0] MODE_IA = 2'b01;
  localparam logic [1:0] MODE_DB = 2'b10;
  localparam logic [1:0] MODE_IB = 2'b11;

  // command carried in tuser
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ANALYZE = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // effect of one instruction on the frame state
  typedef struct packed {
    logic  move;      // add delta to frame (and to a known lr offset)
    word_t delta;
    logic  lr_set;    // overwrite lr offset
    word_t lr_value;
  } effect_t;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < 16; i++) begin
      c = c + {4'd0, v[i]};
    end
    return c;
  endfunction

  // 8-bit immediate rotated right by twice the rotate field
  function automatic word_t rot_imm(input logic [11:0] f);
    logic [2*WORD_W-1:0] dbl;
    logic [4:0]          amt;
    dbl = {{(WORD_W-8){1'b0}}, f[7:0], {(WORD_W-8){1'b0}}, f[7:0]};
    amt = {f[11:8], 1'b0};
    return dbl[amt +: WORD_W];
  endfunction

endpackage

// ===== sv/arm_stack_frame_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_stack_frame_tracker_top
// tracks stack frame size and saved lr offset over a stream of arm words
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser
//  s_*     | in  | instruction, load_frame_size, load_lr_offset (96) | cmd
//  m_*     | out | frame_size, lr_offset (64)                        | lr_known
//
//  one word per cycle sustained while the output is not stalled; a word
//  sits in the input register, where decode, popcount and the frame add
//  are done, then lands in the output register together with the state update.
//  output valid is set from the input register's valid when the word advances.
//  rst clears both stages; frame size resets to 0, lr offset to unknown (-1).
//  a stalled output keeps its word; the input register still fills behind it.
// ----------------------------------------------------------------------------
module arm_stack_frame_tracker_top
  import asft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // instruction, load_frame_size, load_lr_offset
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // frame_size, lr_offset
  output logic        m_tuser    // lr_known
);

  logic  in_valid;
  logic  in_cmd;
  word_t in_instr;
  word_t in_frame;
  word_t in_lr;

  word_t frame_bytes;
  word_t saved_lr_pos;
  word_t frame_bytes_next;
  word_t saved_lr_pos_next;

  logic  advance;
  effect_t eff;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // decode
  logic [3:0]  cond, op, rn, rd;
  logic [2:0]  cls;
  logic        bit_p, bit_u, bit_w, bit_l;
  logic [4:0]  n_regs, k_pos;
  word_t       bytes, k4, ls_off, cp_off, imm;
  logic        lr_store;

  always_comb begin
    cond   = in_instr[31:28];
    cls    = in_instr[27:25];
    op     = in_instr[24:21];
    bit_p  = in_instr[24];
    bit_u  = in_instr[23];
    bit_w  = in_instr[21];
    bit_l  = in_instr[20];
    rn     = in_instr[19:16];
    rd     = in_instr[15:12];
    n_regs = popcount16(in_instr[15:0]);
    k_pos  = popcount16({2'b00, in_instr[13:0]});
    bytes  = {{(WORD_W-7){1'b0}}, n_regs, 2'b00};
    k4     = {{(WORD_W-7){1'b0}}, k_pos, 2'b00};
    imm    = rot_imm(in_instr[11:0]);
    ls_off = {{(WORD_W-12){1'b0}}, in_instr[11:0]};
    if (bit_u) begin
      ls_off = '0 - ls_off;
    end
    cp_off = {{(WORD_W-10){1'b0}}, in_instr[7:0], 2'b00};
    if (bit_u) begin
      cp_off = '0 - cp_off;
    end
    lr_store = !bit_l && (rd == REG_LR);

    eff = '0;
    if (cond == COND_ALWAYS && rn == REG_SP) begin
      unique case (cls)
        CLS_DP_IMM: begin
          if (rd == REG_SP) begin
            if (op == OP_SUB) begin
              eff.move  = 1'b1;
              eff.delta = imm;
            end else if (op == OP_ADD) begin
              eff.move  = 1'b1;
              eff.delta = '0 - imm;
            end
          end
        end
        CLS_LS_IMM: begin
          eff.delta    = ls_off;
          eff.lr_set   = lr_store;
          eff.lr_value = ls_off;
          if (bit_p) begin
            if (bit_w) begin
              eff.move     = 1'b1;
              eff.lr_value = '0;
            end
          end else begin
            eff.move = 1'b1;
          end
        end
        CLS_BLOCK: begin
          if (n_regs != '0) begin
            eff.move   = bit_w;
            eff.lr_set = !bit_l && in_instr[REG_LR];
            unique case ({bit_p, bit_u})
              MODE_IA: begin
                eff.delta    = '0 - bytes;
                eff.lr_value = k4 - bytes;
              end
              MODE_IB: begin
                eff.delta    = '0 - bytes;
                eff.lr_value = k4 + word_t'(4) - bytes;
              end
              MODE_DA: begin
                eff.delta    = bytes;
                eff.lr_value = k4 + word_t'(4);
              end
              MODE_DB: begin
                eff.delta    = bytes;
                eff.lr_value = k4;
              end
            endcase
          end
        end
        CLS_COPROC: begin
          eff.move  = bit_w;
          eff.delta = cp_off;
        end
        CLS_DP_REG, CLS_LS_REG, CLS_BRANCH, CLS_OTHER: begin
          eff = '0;
        end
      endcase
    end
  end

  always_comb begin
    frame_bytes_next  = frame_bytes;
    saved_lr_pos_next = saved_lr_pos;
    if (in_cmd == CMD_LOAD) begin
      frame_bytes_next  = in_frame;
      saved_lr_pos_next = in_lr;
    end else begin
      if (eff.move) begin
        frame_bytes_next = frame_bytes + eff.delta;
        if (saved_lr_pos != UNKNOWN_POS) begin
          saved_lr_pos_next = saved_lr_pos + eff.delta;
        end
      end
      if (eff.lr_set) begin
        saved_lr_pos_next = eff.lr_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      frame_bytes  <= '0;
      saved_lr_pos <= UNKNOWN_POS;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid     <= 1'b1;
        frame_bytes  <= frame_bytes_next;
        saved_lr_pos <= saved_lr_pos_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_instr <= s_tdata[31:0];
      in_frame <= s_tdata[63:32];
      in_lr    <= s_tdata[95:64];
    end
    if (advance) begin
      m_tdata <= {saved_lr_pos_next, frame_bytes_next};
      m_tuser <= (saved_lr_pos_next != UNKNOWN_POS);
    end
  end

endmodule

// ===== test/arm_stack_frame_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_tracker_checker
// watches both stream channels of the stack frame tracker, predicts the frame
// size and saved lr offset for every accepted input word and compares each
// output word against the oldest prediction
// ----------------------------------------------------------------------------
module frame_tracker_checker
  import asft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,   // instruction, load_frame_size, load_lr_offset
  input  logic        s_tuser,   // cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // frame_size, lr_offset
  input  logic        m_tuser,   // lr_known
  output int          fail_count,
  output int          pending
);

  localparam int POS_P = 24;
  localparam int POS_U = 23;
  localparam int POS_W = 21;
  localparam int POS_L = 20;

  typedef struct {
    word_t frame_size;
    word_t lr_offset;
    logic  lr_known;
  } frame_state_t;

  frame_state_t frame_state_q[$];
  word_t        frame_sz;
  word_t        lr_pos;

  // frame moves carry a known lr offset along with them
  function automatic void shift_frame(input word_t d, inout word_t fsz, inout word_t lrp);
    fsz = fsz + d;
    if (lrp != UNKNOWN_POS) begin
      lrp = lrp + d;
    end
  endfunction

  function automatic void track_word(input word_t w, inout word_t fsz, inout word_t lrp);
    logic [2:0] cls;
    logic [3:0] op;
    logic [3:0] rn;
    logic [3:0] rd;
    logic [5:0] rot;
    logic       lr_store;
    logic       has_lr;
    word_t      off;
    word_t      n;
    word_t      k;
    word_t      bytes;
    cls = w[27:25];
    op  = w[24:21];
    rn  = w[19:16];
    rd  = w[15:12];
    if (w[31:28] != COND_ALWAYS) begin
      return;
    end
    case (cls)
      CLS_DP_IMM: begin
        if (rn == REG_SP && rd == REG_SP && (op == OP_SUB || op == OP_ADD)) begin
          rot = {w[11:8], 1'b0};
          off = {24'd0, w[7:0]};
          off = (off >> rot) | (off << (6'd32 - rot));
          shift_frame((op == OP_SUB) ? off : -off, fsz, lrp);
        end
      end
      CLS_LS_IMM: begin
        if (rn == REG_SP) begin
          lr_store = !w[POS_L] && rd == REG_LR;
          off = {20'd0, w[11:0]};
          if (w[POS_U]) begin
            off = -off;
          end
          if (w[POS_P]) begin
            if (w[POS_W]) begin
              shift_frame(off, fsz, lrp);
              if (lr_store) begin
                lrp = '0;
              end
            end else if (lr_store) begin
              lrp = off;
            end
          end else begin
            shift_frame(off, fsz, lrp);
            if (lr_store) begin
              lrp = off;
            end
          end
        end
      end
      CLS_BLOCK: begin
        if (rn == REG_SP) begin
          n = '0;
          k = '0;
          has_lr = 1'b0;
          for (int i = 0; i < 16; i++) begin
            if (w[i]) begin
              if (i == REG_LR) begin
                has_lr = 1'b1;
                k = n;
              end
              n = n + 1;
            end
          end
          if (n != 0) begin
            bytes = n << 2;
            has_lr = has_lr && !w[POS_L];
            case ({w[POS_P], w[POS_U]})
              MODE_IA: begin
                if (w[POS_W]) shift_frame(-bytes, fsz, lrp);
                if (has_lr) lrp = (k << 2) - bytes;
              end
              MODE_IB: begin
                if (w[POS_W]) shift_frame(-bytes, fsz, lrp);
                if (has_lr) lrp = (k << 2) + 4 - bytes;
              end
              MODE_DA: begin
                if (w[POS_W]) shift_frame(bytes, fsz, lrp);
                if (has_lr) lrp = (k << 2) + 4;
              end
              default: begin
                if (w[POS_W]) shift_frame(bytes, fsz, lrp);
                if (has_lr) lrp = k << 2;
              end
            endcase
          end
        end
      end
      CLS_COPROC: begin
        if (rn == REG_SP && w[POS_W]) begin
          off = {22'd0, w[7:0], 2'b00};
          shift_frame(w[POS_U] ? -off : off, fsz, lrp);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    frame_state_t got;
    frame_state_t want;
    if (rst) begin
      frame_state_q.delete();
      frame_sz   = '0;
      lr_pos     = UNKNOWN_POS;
      fail_count = 0;
      pending <= 0;
    end else begin
      // output side first: a word leaving now is always older than one entering
      if (m_tvalid && m_tready) begin
        got.frame_size = m_tdata[31:0];
        got.lr_offset  = m_tdata[63:32];
        got.lr_known   = m_tuser;
        if (frame_state_q.size() == 0) begin
          $error("output word with nothing expected: frame_size %h lr_offset %h",
                 got.frame_size, got.lr_offset);
          fail_count++;
        end else begin
          want = frame_state_q.pop_front();
          if (got.frame_size !== want.frame_size) begin
            $error("frame_size: expected %h, actual %h", want.frame_size, got.frame_size);
            fail_count++;
          end
          if (got.lr_offset !== want.lr_offset) begin
            $error("lr_offset: expected %h, actual %h", want.lr_offset, got.lr_offset);
            fail_count++;
          end
          if (got.lr_known !== want.lr_known) begin
            $error("lr_known: expected %b, actual %b", want.lr_known, got.lr_known);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD) begin
          frame_sz = s_tdata[63:32];
          lr_pos   = s_tdata[95:64];
        end else begin
          track_word(s_tdata[31:0], frame_sz, lr_pos);
        end
        want.frame_size = frame_sz;
        want.lr_offset  = lr_pos;
        want.lr_known   = (lr_pos != UNKNOWN_POS);
        frame_state_q.push_back(want);
      end
      pending <= frame_state_q.size();
    end
  end

endmodule

// ===== test/tb_arm_stack_frame_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_stack_frame_tracker_top
// drives directed and random instruction words and frame presets into the
// stack frame tracker with random idle bursts on both channels; checking is
// done by frame_tracker_checker
// ----------------------------------------------------------------------------
module tb_arm_stack_frame_tracker_top;
  import asft_pkg::*;

  localparam int HANG_LIMIT   = 5000;
  localparam int RANDOM_WORDS = 1125;
  localparam int STEADY_WORDS = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // instruction, load_frame_size, load_lr_offset
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // frame_size, lr_offset
  logic        m_tuser;        // lr_known

  int fail_count;
  int pending;
  int hang_cycles = 0;
  int stall_left = 0;
  int rx_window = 0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;
  bit steady = 1'b0;

  arm_stack_frame_tracker_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  frame_tracker_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall bursts, with calm windows and none in the final stretch
  always @(posedge clk) begin
    if (rx_window == 0) begin
      rx_calm   <= ($urandom_range(0, 2) == 0);
      rx_window <= 200;
    end else begin
      rx_window <= rx_window - 1;
    end
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && !rx_calm && $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("arm_stack_frame_tracker_top test failed");
        $finish;
      end
    end
  end

  task automatic push_word(input logic cmd, input word_t instr, input word_t fsz,
                           input word_t lro);
    int gap;
    if (!steady && !tx_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {lro, fsz, instr};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic analyze_word(input word_t instr);
    push_word(CMD_ANALYZE, instr, $urandom(), $urandom());
  endtask

  task automatic preset_frame(input word_t fsz, input word_t lro);
    push_word(CMD_LOAD, $urandom(), fsz, lro);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly unconditional words aimed at sp with random content
  function automatic word_t pick_word();
    word_t w;
    int    pick;
    w = $urandom();
    if ($urandom_range(0, 9) < 2) begin
      return w;
    end
    w[31:28] = COND_ALWAYS;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: w[27:25] = CLS_DP_IMM;
      3:       w[27:25] = CLS_DP_REG;
      4, 5:    w[27:25] = CLS_LS_IMM;
      6, 7:    w[27:25] = CLS_BLOCK;
      8:       w[27:25] = CLS_COPROC;
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      w[19:16] = REG_SP;
    end
    case (w[27:25])
      CLS_DP_IMM, CLS_DP_REG: begin
        if ($urandom_range(0, 3) != 0) w[15:12] = REG_SP;
        if ($urandom_range(0, 3) != 0) w[24:21] = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
      end
      CLS_LS_IMM, CLS_LS_REG: begin
        if ($urandom_range(0, 1) != 0) w[15:12] = REG_LR;
      end
      CLS_BLOCK: begin
        if ($urandom_range(0, 2) == 0) begin
          w[15:0] = w[15:0] & 16'($urandom()) & 16'($urandom());
        end
        if ($urandom_range(0, 1) != 0) w[REG_LR] = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    word_t lro;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    preset_frame(32'h0000_0000, UNKNOWN_POS);
    preset_frame(32'h7fff_ffff, 32'h8000_0000);
    preset_frame(32'hffff_ffff, 32'h0000_0000);
    analyze_word(32'he24d_d0ff);  // sub sp, sp, #0xff
    analyze_word(32'he24d_d1ff);  // rotated immediate
    analyze_word(32'he24d_dfff);  // largest rotate
    analyze_word(32'he28d_d010);  // add sp, sp, #16
    analyze_word(32'h024d_d010);  // conditional, ignored
    analyze_word(32'he00d_d09d);  // multiply / extra load-store space
    analyze_word(32'he04d_d00e);  // register operand
    analyze_word(32'he34d_d010);  // compare-class opcode
    analyze_word(32'he24d_c010);  // rd not sp
    analyze_word(32'he52d_e004);  // str lr, pre-indexed with writeback
    analyze_word(32'he58d_e008);  // str lr, pre-indexed no writeback
    analyze_word(32'he48d_e004);  // str lr, post-indexed
    analyze_word(32'he59d_e008);  // ldr
    analyze_word(32'he78d_e000);  // register offset, ignored
    analyze_word(32'he92d_4010);  // stmdb sp!, {r4, lr}
    analyze_word(32'he8ad_4000);  // stmia sp!, {lr}
    analyze_word(32'he9ad_40ff);  // stmib
    analyze_word(32'he82d_c001);  // stmda
    analyze_word(32'he8bd_8000);  // ldmia sp!, {pc}
    analyze_word(32'he92d_0000);  // empty register list
    analyze_word(32'he92d_ffff);  // full register list
    analyze_word(32'hed2d_0002);  // stc with writeback
    analyze_word(32'hecad_00ff);  // ldc/stc up with writeback
    analyze_word(32'hed0d_0001);  // no writeback
    analyze_word(32'hea00_0000);  // branch
    analyze_word(32'hffff_ffff);
    preset_frame(32'h0000_0010, 32'hffff_fffb);
    analyze_word(32'he24d_d004);  // known lr offset lands on -1
    analyze_word(32'he24d_d004);

    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_WORDS / 2) begin
        drain_results();
      end
      if (i == RANDOM_WORDS - STEADY_WORDS) begin
        steady = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       lro = UNKNOWN_POS;
          1:       lro = $urandom_range(0, 64);
          default: lro = $urandom();
        endcase
        preset_frame($urandom(), lro);
      end else begin
        analyze_word(pick_word());
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("arm_stack_frame_tracker_top test passed");
    end else begin
      $display("arm_stack_frame_tracker_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/asft_pkg.sv
sv/arm_stack_frame_tracker_top.sv
test/arm_stack_frame_tracker_checker.sv
test/tb_arm_stack_frame_tracker_top.sv
